### rtl/mgr_pkg.sv
package mgr_pkg;

  // Geometry limits of the line store and the position counters
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  // Register widths
  localparam int unsigned MOD_W  = 9;
  localparam int unsigned COEF_W = 8;
  localparam int unsigned GEOM_W = 11;
  localparam int unsigned CELL_W = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = GEOM_W;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;

  // Largest modulus the byte-wide cells allow
  localparam int unsigned MOD_MAX = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS      = 3'd0,
    REG_OFFSET_TERM  = 3'd1,
    REG_GAIN_UP      = 3'd2,
    REG_GAIN_LEFT    = 3'd3,
    REG_GAIN_DIAG    = 3'd4,
    REG_FRAME_WIDTH  = 3'd5,
    REG_FRAME_HEIGHT = 3'd6
  } cfg_reg_e;

  // Effective settings, already clamped to their legal ranges
  typedef struct packed {
    logic [MOD_W-1:0]  modulus;
    logic [COEF_W-1:0] offset_term;
    logic [COEF_W-1:0] gain_up;
    logic [COEF_W-1:0] gain_left;
    logic [COEF_W-1:0] gain_diag;
    logic [GEOM_W-1:0] width;
    logic [GEOM_W-1:0] height;
  } cfg_t;

  // One classified pixel, handed from front to back
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_end;
    logic             is_row0;
    logic             is_col0;
  } task_t;

  function automatic logic [MOD_W-1:0] eff_modulus(input logic [MOD_W-1:0] raw);
    logic [MOD_W-1:0] res;
    if (raw == '0) begin
      res = MOD_W'(1);
    end else if (raw > MOD_W'(MOD_MAX)) begin
      res = MOD_W'(MOD_MAX);
    end else begin
      res = raw;
    end
    return res;
  endfunction

  function automatic logic [GEOM_W-1:0] eff_limit(input logic [GEOM_W-1:0] raw,
                                                  input logic [GEOM_W-1:0] lim);
    logic [GEOM_W-1:0] res;
    if (raw == '0) begin
      res = GEOM_W'(1);
    end else if (raw > lim) begin
      res = lim;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

### rtl/mgr_queue.sv
module mgr_queue import mgr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output task_t data_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  task_t            slot_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store the beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/mgr_front.sv
module mgr_front import mgr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  push_i,
  input  logic  restart_i,
  input  logic  q_full_i,
  output logic  q_push_o,
  output task_t q_data_o
);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  c0, c1;
  logic [ROW_W-1:0]  r0, r2;
  logic [GEOM_W-1:0] r1;
  logic              wrap_c, last_c, last_r;

  assign q_push_o = push_i && !q_full_i;

  // Resolve the position of this pixel and the one after it
  always_comb begin
    c0     = restart_i ? '0 : col_q;
    r0     = restart_i ? '0 : row_q;
    wrap_c = (GEOM_W'(c0) >= cfg_i.width);
    c1     = wrap_c ? '0 : c0;
    r1     = wrap_c ? GEOM_W'(r0) + 1'b1 : GEOM_W'(r0);
    r2     = (r1 >= cfg_i.height) ? '0 : r1[ROW_W-1:0];
    last_c = (GEOM_W'(c1) == cfg_i.width - 1'b1);
    last_r = (GEOM_W'(r2) == cfg_i.height - 1'b1);

    if (last_c) begin
      col_d = '0;
      row_d = last_r ? '0 : r2 + 1'b1;
    end else begin
      col_d = c1 + 1'b1;
      row_d = r2;
    end

    q_data_o.row       = r2;
    q_data_o.col       = c1;
    q_data_o.frame_end = last_c && last_r;
    q_data_o.is_row0   = (r2 == '0);
    q_data_o.is_col0   = (c1 == '0);
  end

  // Advance the raster position on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (q_push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### rtl/mgr_back.sv
module mgr_back import mgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              q_empty_i,
  input  task_t             q_data_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [CELL_W-1:0] cell_value_o,
  output logic [ROW_W-1:0]  row_index_o,
  output logic [COL_W-1:0]  col_index_o,
  output logic              frame_end_o
);

  localparam int unsigned PROD_W    = 2 * COEF_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned MOD_STEPS = SUM_W / 2;
  localparam int unsigned CNT_W     = $clog2(MOD_STEPS);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_MOD, B_DONE} state_e;
  typedef enum logic [1:0] {T_UP, T_LEFT, T_DIAG} term_e;

  state_e             state_q;
  term_e              term_q;
  task_t              task_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]   acc_q, div_q, sum;
  logic [CELL_W-1:0]  rem_q, left_q, diag_q;
  logic               out_valid_q;
  logic [CELL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [MOD_W-1:0]   t1, t2, r1, r2;
  logic               rd_en, wr_en;
  logic [CELL_W-1:0]  rd_q;
  logic [CELL_W-1:0]  mem [MAX_WIDTH];

  assign rd_en   = (state_q == B_IDLE) && !q_empty_i;
  assign q_pop_o = rd_en;
  assign wr_en   = (state_q == B_DONE) && (!out_valid_q || pop_i);
  assign empty_o = !out_valid_q;

  // Select one product term per cycle
  always_comb begin
    case (term_q)
      T_UP: begin
        mul_a = rd_q;
        mul_b = cfg_i.gain_up;
      end
      T_LEFT: begin
        mul_a = left_q;
        mul_b = cfg_i.gain_left;
      end
      T_DIAG: begin
        mul_a = diag_q;
        mul_b = cfg_i.gain_diag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    sum  = acc_q + SUM_W'(prod);
  end

  // Reduce two dividend bits per cycle; remainder stays below the modulus
  always_comb begin
    t1 = {rem_q, div_q[SUM_W-1]};
    r1 = (t1 >= cfg_i.modulus) ? t1 - cfg_i.modulus : t1;
    t2 = {r1[CELL_W-1:0], div_q[SUM_W-2]};
    r2 = (t2 >= cfg_i.modulus) ? t2 - cfg_i.modulus : t2;
  end

  // Line store of the previous row
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[q_data_i.col];
    end
    if (wr_en) begin
      mem[task_q.col] <= rem_q;
    end
  end

  // Sequence one pixel: read, multiply-accumulate, reduce, commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      term_q       <= T_UP;
      task_q       <= '0;
      cnt_q        <= '0;
      acc_q        <= '0;
      div_q        <= '0;
      rem_q        <= '0;
      left_q       <= '0;
      diag_q       <= '0;
      out_valid_q  <= 1'b0;
      cell_value_o <= '0;
      row_index_o  <= '0;
      col_index_o  <= '0;
      frame_end_o  <= 1'b0;
    end else begin
      // Drop the result once taken
      if (pop_i && out_valid_q && !wr_en) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        B_IDLE: begin
          if (rd_en) begin
            task_q  <= q_data_i;
            acc_q   <= SUM_W'(cfg_i.offset_term);
            term_q  <= T_UP;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          acc_q <= sum;
          if (term_q == T_DIAG) begin
            if (task_q.is_row0) begin
              div_q <= SUM_W'(task_q.col);
            end else if (task_q.is_col0) begin
              div_q <= SUM_W'(task_q.row);
            end else begin
              div_q <= sum;
            end
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= B_MOD;
          end else if (term_q == T_UP) begin
            term_q <= T_LEFT;
          end else begin
            term_q <= T_DIAG;
          end
        end
        B_MOD: begin
          rem_q <= r2[CELL_W-1:0];
          div_q <= div_q << 2;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (wr_en) begin
            left_q       <= rem_q;
            diag_q       <= rd_q;
            out_valid_q  <= 1'b1;
            cell_value_o <= rem_q;
            row_index_o  <= task_q.row;
            col_index_o  <= task_q.col;
            frame_end_o  <= task_q.frame_end;
            state_q      <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/modular_grid_recurrence_raster.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | push / full          | restart_i
// result   | empty / pop          | cell_value_o, row_index_o, col_index_o, frame_end_o
// config   | cfg_valid_i / ready  | cfg_index_i, cfg_data_i (ready is always high)
//
// Each pixel passes through the back end in order: one line-store read, multiply-accumulate
// of the three terms through one shared 8x8 multiplier, modulus reduction at two dividend
// bits per cycle, and one commit.
// The front resolves raster position at accept time and queues up to two pixels.
// A result waiting on pop stalls only the commit; the queue keeps taking beats until full.
// Reset clears position and neighbors and sets settings to defaults; the line store is not cleared.
module modular_grid_recurrence_raster import mgr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  restart_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [CELL_W-1:0]     cell_value_o,
  output logic [ROW_W-1:0]      row_index_o,
  output logic [COL_W-1:0]      col_index_o,
  output logic                  frame_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [MOD_W-1:0]  modulus_q;
  logic [COEF_W-1:0] offset_q, gain_up_q, gain_left_q, gain_diag_q;
  logic [GEOM_W-1:0] width_q, height_q;
  cfg_t              cfg;
  logic              q_push, q_full, q_pop, q_empty;
  task_t             q_in, q_out;

  assign cfg_ready_o = 1'b1;

  // Hold the settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= MOD_W'(MOD_MAX);
      offset_q    <= '0;
      gain_up_q   <= COEF_W'(1);
      gain_left_q <= COEF_W'(1);
      gain_diag_q <= '0;
      width_q     <= GEOM_W'(MAX_WIDTH);
      height_q    <= GEOM_W'(MAX_HEIGHT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MODULUS:      modulus_q   <= cfg_data_i[MOD_W-1:0];
        REG_OFFSET_TERM:  offset_q    <= cfg_data_i[COEF_W-1:0];
        REG_GAIN_UP:      gain_up_q   <= cfg_data_i[COEF_W-1:0];
        REG_GAIN_LEFT:    gain_left_q <= cfg_data_i[COEF_W-1:0];
        REG_GAIN_DIAG:    gain_diag_q <= cfg_data_i[COEF_W-1:0];
        REG_FRAME_WIDTH:  width_q     <= cfg_data_i[GEOM_W-1:0];
        REG_FRAME_HEIGHT: height_q    <= cfg_data_i[GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to legal ranges
  always_comb begin
    cfg.modulus     = eff_modulus(modulus_q);
    cfg.offset_term = offset_q;
    cfg.gain_up     = gain_up_q;
    cfg.gain_left   = gain_left_q;
    cfg.gain_diag   = gain_diag_q;
    cfg.width       = eff_limit(width_q, GEOM_W'(MAX_WIDTH));
    cfg.height      = eff_limit(height_q, GEOM_W'(MAX_HEIGHT));
  end

  assign full = q_full;

  mgr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .push_i    (push),
    .restart_i (restart_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_in)
  );

  mgr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  mgr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_empty_i    (q_empty),
    .q_data_i     (q_out),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .cell_value_o (cell_value_o),
    .row_index_o  (row_index_o),
    .col_index_o  (col_index_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

### rtl/mgr_checker.sv
module mgr_checker import mgr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  push,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [CELL_W-1:0]     cell_value_i,
  input logic [ROW_W-1:0]      row_index_i,
  input logic [COL_W-1:0]      col_index_i,
  input logic                  frame_end_i,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_i,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [MOD_W-1:0] mod_q;
  logic [MOD_W-1:0] eff_mod;
  logic [2:0]       pend_q;
  logic             in_beat, out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;
  assign eff_mod  = eff_modulus(mod_q);

  // Track the modulus and the number of beats in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= MOD_W'(MOD_MAX);
      pend_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && (cfg_index_i == REG_MODULUS)) begin
        mod_q <= cfg_data_i[MOD_W-1:0];
      end
      if (in_beat && !out_beat) begin
        pend_q <= pend_q + 1'b1;
      end else if (out_beat && !in_beat) begin
        pend_q <= pend_q - 1'b1;
      end
    end
  end

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(cell_value_i) && $stable(row_index_i)
                          && $stable(col_index_i) && $stable(frame_end_i)))
    else $error("result changed or vanished while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != '0))
    else $error("result shown with no input beat outstanding");

  a_below_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ({1'b0, cell_value_i} < eff_mod))
    else $error("cell value not below modulus");

  a_top_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (row_index_i == '0) && (col_index_i < COL_W'(eff_mod)))
      |-> (cell_value_i == col_index_i[CELL_W-1:0]))
    else $error("top row cell does not equal its column");

endmodule

bind modular_grid_recurrence_raster mgr_checker u_mgr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .cell_value_i (cell_value_o),
  .row_index_i  (row_index_o),
  .col_index_i  (col_index_o),
  .frame_end_i  (frame_end_o),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_i  (cfg_ready_o),
  .cfg_index_i  (cfg_index_i),
  .cfg_data_i   (cfg_data_i)
);
